[sv/bmcd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bmcd_pkg
// Shared widths, register indexes, event codes and types for the push-button
// click and long-press detector.
// ----------------------------------------------------------------------------
package bmcd_pkg;

   localparam int TIME_W    = 32;
   localparam int CODE_W    = 8;
   localparam int CSR_IDX_W = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEAD_WINDOW  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_THRESH  = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE     = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_LEVEL = 8'd3;

   // register reset values
   localparam logic [TIME_W-1:0] DEAD_WINDOW_RESET = 32'd400;
   localparam logic [TIME_W-1:0] LONG_THRESH_RESET = 32'd1000;
   localparam logic [TIME_W-1:0] DEBOUNCE_RESET    = 32'd50;
   localparam logic              ACTIVE_LVL_RESET  = 1'b0;

   // event codes
   localparam logic [CODE_W-1:0] EVT_NONE         = 8'd0;
   localparam logic [CODE_W-1:0] EVT_LONG_HOLD    = 8'd1;
   localparam logic [CODE_W-1:0] EVT_LONG_RELEASE = 8'd2;

   // click tally: idle value means no clicks pending, saturates at max
   localparam logic [CODE_W-1:0] TALLY_IDLE = 8'd2;
   localparam logic [CODE_W-1:0] TALLY_MAX  = 8'd255;

   typedef struct packed {
      logic [TIME_W-1:0] dead_window_ms;
      logic [TIME_W-1:0] long_threshold_ms;
      logic [TIME_W-1:0] debounce_threshold_ms;
      logic              active_level;
   } cfg_type;

endpackage
`default_nettype wire

[sv/bmcd_req_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bmcd_req_if
// Sample channel: timestamp and pin level with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bmcd_req_if
   import bmcd_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] now_ms;
   logic              pin_level;

   modport source (output valid, output now_ms, output pin_level, input ready);
   modport sink   (input valid, input now_ms, input pin_level, output ready);
endinterface
`default_nettype wire

[sv/bmcd_rsp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bmcd_rsp_if
// Event channel: one event code per sample with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bmcd_rsp_if
   import bmcd_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] event_code;

   modport source (output valid, output event_code, input ready);
   modport sink   (input valid, input event_code, output ready);
endinterface
`default_nettype wire

[sv/bmcd_csr_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bmcd_csr_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bmcd_csr_if
   import bmcd_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [TIME_W-1:0]    wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

[sv/bmcd_cfg_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bmcd_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module bmcd_cfg_regs
   import bmcd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 wr_en,
   input  wire logic [CSR_IDX_W-1:0] wr_index,
   input  wire logic [TIME_W-1:0]    wr_data,
   output cfg_type                   cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_DEAD_WINDOW:  cfg_in.dead_window_ms        = wr_data;
            CSR_LONG_THRESH:  cfg_in.long_threshold_ms     = wr_data;
            CSR_DEBOUNCE:     cfg_in.debounce_threshold_ms = wr_data;
            CSR_ACTIVE_LEVEL: cfg_in.active_level          = wr_data[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dead_window_ms        <= DEAD_WINDOW_RESET;
         cfg_ff.long_threshold_ms     <= LONG_THRESH_RESET;
         cfg_ff.debounce_threshold_ms <= DEBOUNCE_RESET;
         cfg_ff.active_level          <= ACTIVE_LVL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

`ifndef SYNTH
   a_bad_index_ignored: assert property (@(posedge clock) disable iff (reset)
      (wr_en && wr_index != CSR_DEAD_WINDOW && wr_index != CSR_LONG_THRESH &&
       wr_index != CSR_DEBOUNCE && wr_index != CSR_ACTIVE_LEVEL) |=> $stable(cfg_ff))
      else $error("write to unknown index changed configuration");
   a_no_write_holds: assert property (@(posedge clock) disable iff (reset)
      !wr_en |=> $stable(cfg_ff))
      else $error("configuration changed without a write");
   a_reset_value: assert property (@(posedge clock)
      reset |=> (cfg_ff.dead_window_ms == DEAD_WINDOW_RESET &&
                 cfg_ff.active_level == ACTIVE_LVL_RESET))
      else $error("configuration reset value wrong");
`endif

endmodule
`default_nettype wire

[sv/bmcd_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bmcd_step
// Detector state and the per-sample update that yields one event code.
// ----------------------------------------------------------------------------
module bmcd_step
   import bmcd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfg_type           cfg,
   input  wire logic              accept,
   input  wire logic [TIME_W-1:0] now_ms,
   input  wire logic              pin_level,
   output logic [CODE_W-1:0]      event_code
);

   logic [TIME_W-1:0] press_duration_ff, press_duration_in;
   logic [TIME_W-1:0] last_sample_ff, last_sample_in;
   logic [TIME_W-1:0] last_event_ff, last_event_in;
   logic              long_reported_ff, long_reported_in;
   logic [CODE_W-1:0] click_tally_ff, click_tally_in;

   logic [TIME_W-1:0] held_duration;
   logic [TIME_W-1:0] expiry_time;
   logic              was_long;
   logic              was_click;
   logic [CODE_W-1:0] tally_mid;

   always_comb begin
      press_duration_in = press_duration_ff;
      last_event_in     = last_event_ff;
      long_reported_in  = long_reported_ff;
      click_tally_in    = click_tally_ff;
      last_sample_in    = now_ms;
      event_code        = EVT_NONE;

      held_duration = press_duration_ff + (now_ms - last_sample_ff);
      was_long      = press_duration_ff > cfg.long_threshold_ms;
      was_click     = (press_duration_ff > cfg.debounce_threshold_ms) && !was_long;

      // long release drops pending clicks; a click bumps the saturating tally
      if (was_long) begin
         tally_mid = TALLY_IDLE;
      end else if (was_click && click_tally_ff != TALLY_MAX) begin
         tally_mid = click_tally_ff + 8'd1;
      end else begin
         tally_mid = click_tally_ff;
      end
      expiry_time = ((was_long || was_click) ? now_ms : last_event_ff) + cfg.dead_window_ms;

      if (pin_level == cfg.active_level) begin
         press_duration_in = held_duration;
         if (held_duration > cfg.long_threshold_ms && !long_reported_ff) begin
            event_code       = EVT_LONG_HOLD;
            long_reported_in = 1'b1;
         end
      end else begin
         if (was_long) begin
            event_code = EVT_LONG_RELEASE;
         end
         if (was_long || was_click) begin
            last_event_in = now_ms;
         end
         click_tally_in = tally_mid;
         if (now_ms > expiry_time && tally_mid > TALLY_IDLE) begin
            event_code     = tally_mid;
            click_tally_in = TALLY_IDLE;
         end
         long_reported_in  = 1'b0;
         press_duration_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_duration_ff <= '0;
         last_sample_ff    <= '0;
         last_event_ff     <= '0;
         long_reported_ff  <= 1'b0;
         click_tally_ff    <= TALLY_IDLE;
      end else if (accept) begin
         press_duration_ff <= press_duration_in;
         last_sample_ff    <= last_sample_in;
         last_event_ff     <= last_event_in;
         long_reported_ff  <= long_reported_in;
         click_tally_ff    <= click_tally_in;
      end
   end

`ifndef SYNTH
   a_tally_floor: assert property (@(posedge clock) disable iff (reset)
      click_tally_ff >= TALLY_IDLE)
      else $error("click tally below idle value");
   a_long_hold_latched: assert property (@(posedge clock) disable iff (reset)
      (accept && event_code == EVT_LONG_HOLD) |=> long_reported_ff)
      else $error("long hold reported without latching");
   a_release_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && pin_level != cfg.active_level) |=>
         (press_duration_ff == '0 && !long_reported_ff))
      else $error("release did not clear press state");
   a_single_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && long_reported_ff && pin_level == cfg.active_level) |->
         event_code == EVT_NONE)
      else $error("long hold reported twice");
`endif

endmodule
`default_nettype wire

[sv/bmcd_out_buf.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bmcd_out_buf
// Two-entry result buffer that parts the sample side from the event side.
// ----------------------------------------------------------------------------
module bmcd_out_buf
   import bmcd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic [CODE_W-1:0] in_code,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [CODE_W-1:0]      out_code
);

   logic [CODE_W-1:0] entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_code  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_code;
      end
   end

`ifndef SYNTH
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("result buffer overfilled");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 2'd1)
      else $error("result buffer count lost a push");
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("result buffer pointers out of step");
`endif

endmodule
`default_nettype wire

[sv/button_multi_click_detector_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// button_multi_click_detector_core
// Push-button click and long-press detector: one event code per pin sample.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  ---------+-----------+--------------------------------------
//  req_bus  | in        | now_ms[31:0], pin_level
//  rsp_bus  | out       | event_code[7:0]
//  csr_bus  | in        | index[7:0], wdata[31:0] (always ready)
//
//  one sample is taken per cycle while the result buffer has room; its event
//  code sits in the result buffer from the next cycle
//  the detector state updates in a single pass at the sample transaction
//  a two-entry result buffer keeps req_bus ready while one event waits
//  req_bus ready drops only when both buffer entries are held by rsp_bus stalls
//  synchronous reset restores register defaults and clears detector state
// ----------------------------------------------------------------------------
module button_multi_click_detector_core
   import bmcd_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   bmcd_req_if.sink   req_bus,
   bmcd_rsp_if.source rsp_bus,
   bmcd_csr_if.sink   csr_bus
);

   cfg_type           cfg;
   logic              sample_accept;
   logic              buf_ready;
   logic [CODE_W-1:0] step_code;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = buf_ready;
   assign sample_accept = req_bus.valid && buf_ready;

   bmcd_cfg_regs u_cfg_regs (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_bus.valid),
      .wr_index (csr_bus.index),
      .wr_data  (csr_bus.wdata),
      .cfg      (cfg)
   );

   bmcd_step u_step (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .accept     (sample_accept),
      .now_ms     (req_bus.now_ms),
      .pin_level  (req_bus.pin_level),
      .event_code (step_code)
   );

   bmcd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (buf_ready),
      .in_code   (step_code),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_code  (rsp_bus.event_code)
   );

endmodule
`default_nettype wire

[test/bmcd_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bmcd_checker
// Watches the sample, event and register channels of the click detector,
// keeps its own copy of the detector state and compares every event code
// against the code it works out for the matching sample.
// ----------------------------------------------------------------------------
module bmcd_checker
   import bmcd_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   bmcd_req_if       req_bus,
   bmcd_rsp_if       rsp_bus,
   bmcd_csr_if       csr_bus,
   output int        error_count,
   output int        events_owed
);

   cfg_type           cfg;
   logic [TIME_W-1:0] held_ms;
   logic [TIME_W-1:0] prev_sample_ms;
   logic [TIME_W-1:0] last_click_ms;
   logic              hold_flagged;
   logic [CODE_W-1:0] tally;
   logic [CODE_W-1:0] owed_codes[$];

   function automatic logic [CODE_W-1:0] next_event_code(input logic [TIME_W-1:0] now_ms,
                                                         input logic pin);
      logic [CODE_W-1:0] code;
      logic [TIME_W-1:0] expiry;
      code = EVT_NONE;
      if (pin == cfg.active_level) begin
         held_ms = held_ms + (now_ms - prev_sample_ms);
         if (held_ms > cfg.long_threshold_ms && !hold_flagged) begin
            code         = EVT_LONG_HOLD;
            hold_flagged = 1'b1;
         end
      end else begin
         // a long press drops any clicks still pending
         if (held_ms > cfg.long_threshold_ms) begin
            code          = EVT_LONG_RELEASE;
            last_click_ms = now_ms;
            tally         = TALLY_IDLE;
         end
         if (held_ms > cfg.debounce_threshold_ms && held_ms <= cfg.long_threshold_ms) begin
            if (tally != TALLY_MAX) tally = tally + 8'd1;
            last_click_ms = now_ms;
         end
         expiry = last_click_ms + cfg.dead_window_ms;
         if (now_ms > expiry && tally > TALLY_IDLE) begin
            code  = tally;
            tally = TALLY_IDLE;
         end
         hold_flagged = 1'b0;
         held_ms      = '0;
      end
      prev_sample_ms = now_ms;
      return code;
   endfunction

   always @(posedge clock) begin : watch
      logic [CODE_W-1:0] want;
      if (reset) begin
         cfg.dead_window_ms        = DEAD_WINDOW_RESET;
         cfg.long_threshold_ms     = LONG_THRESH_RESET;
         cfg.debounce_threshold_ms = DEBOUNCE_RESET;
         cfg.active_level          = ACTIVE_LVL_RESET;
         held_ms        = '0;
         prev_sample_ms = '0;
         last_click_ms  = '0;
         hold_flagged   = 1'b0;
         tally          = TALLY_IDLE;
         owed_codes.delete();
         error_count    = 0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               CSR_DEAD_WINDOW:  cfg.dead_window_ms        = csr_bus.wdata;
               CSR_LONG_THRESH:  cfg.long_threshold_ms     = csr_bus.wdata;
               CSR_DEBOUNCE:     cfg.debounce_threshold_ms = csr_bus.wdata;
               CSR_ACTIVE_LEVEL: cfg.active_level          = csr_bus.wdata[0];
               default: ;
            endcase
         end
         // result transaction first: it always belongs to an earlier sample
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (owed_codes.size() == 0) begin
               error_count++;
               $display("%0t: unexpected event, expected none, got %0d", $time,
                        rsp_bus.event_code);
            end else begin
               want = owed_codes.pop_front();
               if (rsp_bus.event_code !== want) begin
                  error_count++;
                  $display("%0t: event_code mismatch, expected %0d, got %0d", $time, want,
                           rsp_bus.event_code);
               end
            end
         end
         if (req_bus.valid && req_bus.ready)
            owed_codes.push_back(next_event_code(req_bus.now_ms, req_bus.pin_level));
      end
      events_owed = owed_codes.size();
   end

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the button click detector: a directed run of presses, clicks
// and long holds, then random gestures under several register settings and
// idling patterns. The checker beside the block does all the comparing.
// ----------------------------------------------------------------------------
module testbench;
   import bmcd_pkg::*;

   localparam int HALF_PERIOD     = 4;
   localparam int RESET_CYCLES    = 12;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 4;
   localparam int FLOOD_CLICKS    = 260;

   logic clock = 1'b0;
   logic reset;
   int   error_count;
   int   events_owed;
   int   cycle_count = 0;
   int   gap_pct     = 0;
   int   stall_pct   = 0;
   int   hold_ticket = 0;
   int   samples_sent = 0;

   // stimulus-side copy of the registers, used only to shape gestures
   logic [TIME_W-1:0] stamp;
   logic [TIME_W-1:0] dead_ms;
   logic [TIME_W-1:0] long_ms;
   logic [TIME_W-1:0] deb_ms;
   logic              act_lvl;

   bmcd_req_if req_bus();
   bmcd_rsp_if rsp_bus();
   bmcd_csr_if csr_bus();

   button_multi_click_detector_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   bmcd_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_bus     (csr_bus),
      .error_count (error_count),
      .events_owed (events_owed)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("button_multi_click_detector_core verification failed");
         $finish;
      end
   end

   // event receiver: random stalls plus an occasional long hold-off
   initial begin : receiver
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_ticket != hold_seen) begin
            hold_seen = hold_ticket;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   function automatic logic [TIME_W-1:0] pick_upto(input logic [TIME_W-1:0] lim,
                                                   input int unsigned cap);
      return (lim > cap) ? $urandom_range(cap) : $urandom_range(lim);
   endfunction

   // press length that should register as one click under the current setting, when debounce is below long
   function automatic logic [TIME_W-1:0] click_span();
      logic [TIME_W-1:0] lo;
      if (deb_ms >= long_ms) return $urandom;
      lo = deb_ms + 1'b1;
      case ($urandom_range(7))
         0:       return lo;
         1:       return long_ms;
         default: return lo + pick_upto(long_ms - lo, 400);
      endcase
   endfunction

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      gap_pct   = sender_pct;
      stall_pct <= receiver_pct;
   endtask

   task automatic send_sample(input logic [TIME_W-1:0] now_ms, input logic pin);
      logic ok;
      while ($urandom_range(99) < gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.now_ms    <= now_ms;
      req_bus.pin_level <= pin;
      do begin
         @(negedge clock);
         ok = req_bus.ready;
         @(posedge clock);
      end while (!ok);
      samples_sent++;
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (events_owed != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [TIME_W-1:0] data);
      logic ok;
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.wdata <= data;
      do begin
         @(negedge clock);
         ok = csr_bus.ready;
         @(posedge clock);
      end while (!ok);
      case (index)
         CSR_DEAD_WINDOW:  dead_ms = data;
         CSR_LONG_THRESH:  long_ms = data;
         CSR_DEBOUNCE:     deb_ms  = data;
         CSR_ACTIVE_LEVEL: act_lvl = data[0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [TIME_W-1:0] dead, input logic [TIME_W-1:0] lng,
                            input logic [TIME_W-1:0] deb, input logic act);
      wait_idle();
      write_reg(CSR_DEAD_WINDOW, dead);
      write_reg(CSR_LONG_THRESH, lng);
      write_reg(CSR_DEBOUNCE, deb);
      // only bit 0 of the level register counts
      write_reg(CSR_ACTIVE_LEVEL, {31'($urandom), act});
      // unmapped index, must leave every register alone
      write_reg(CSR_IDX_W'($urandom_range((1 << CSR_IDX_W) - 1, CSR_ACTIVE_LEVEL + 1)),
                $urandom);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic press_for(input logic [TIME_W-1:0] span, input int pieces);
      logic [TIME_W-1:0] left;
      logic [TIME_W-1:0] step;
      int                i;
      left = span;
      for (i = 0; i < pieces; i++) begin
         step  = (i == pieces - 1) ? left : $urandom_range(left);
         left  = left - step;
         stamp = stamp + step;
         send_sample(stamp, act_lvl);
      end
   endtask

   task automatic release_after(input logic [TIME_W-1:0] rest);
      stamp = stamp + rest;
      send_sample(stamp, ~act_lvl);
   endtask

   task automatic click_burst();
      int clicks;
      int i;
      clicks = $urandom_range(4, 1);
      for (i = 0; i < clicks; i++) begin
         press_for(click_span(), $urandom_range(3, 1));
         release_after(pick_upto(dead_ms, 300));
      end
      // quiet time around the dead window edge
      case ($urandom_range(3))
         0:       release_after(dead_ms);
         1:       release_after(dead_ms + 1'b1);
         2:       release_after(pick_upto(dead_ms, 500));
         default: release_after(dead_ms + 1'b1 + $urandom_range(50));
      endcase
   endtask

   task automatic hold_gesture();
      press_for(long_ms + 1'b1 + $urandom_range(300), $urandom_range(5, 2));
      if ($urandom_range(1)) release_after($urandom_range(100));
      else release_after(dead_ms + 1'b1);
   endtask

   task automatic bounce();
      press_for(deb_ms - pick_upto(deb_ms, 60), $urandom_range(2, 1));
      release_after(pick_upto(dead_ms, 200));
   endtask

   task automatic noise();
      int n;
      int i;
      n = $urandom_range(4, 1);
      for (i = 0; i < n; i++) begin
         if ($urandom_range(1)) stamp = $urandom;
         else stamp = stamp + $urandom_range(2000);
         send_sample(stamp, 1'($urandom_range(1)));
      end
   endtask

   task automatic run_gestures(input int count);
      int target;
      int pick;
      target = samples_sent + count;
      while (samples_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 45) click_burst();
         else if (pick < 65) hold_gesture();
         else if (pick < 80) bounce();
         else noise();
      end
   endtask

   // enough clicks inside one dead window to pin the tally at its maximum
   task automatic click_flood(input int clicks);
      int i;
      for (i = 0; i < clicks; i++) begin
         press_for(1 + $urandom_range(20), 1);
         release_after($urandom_range(30));
      end
      release_after(dead_ms + 1'b1);
   endtask

   // defaults: pressed is pin low, debounce 50, long 1000, dead window 400
   task automatic directed_samples();
      send_sample(32'd0, 1'b1);
      send_sample(32'd10, 1'b0);
      send_sample(32'd20, 1'b1);          // bounce, too short for a click
      send_sample(32'd100, 1'b0);
      send_sample(32'd200, 1'b0);
      send_sample(32'd230, 1'b1);         // first click
      send_sample(32'd300, 1'b0);
      send_sample(32'd360, 1'b1);         // second click
      send_sample(32'd760, 1'b1);         // exactly at the window edge, still quiet
      send_sample(32'd761, 1'b1);         // two clicks reported
      send_sample(32'd800, 1'b0);
      send_sample(32'd1500, 1'b0);
      send_sample(32'd1900, 1'b0);        // long hold
      send_sample(32'd2500, 1'b0);        // long hold reported only once
      send_sample(32'd2600, 1'b1);        // long release
      send_sample(32'd2650, 1'b0);
      send_sample(32'd2660, 1'b1);        // press equal to debounce does not count
      send_sample(32'd3660, 1'b0);
      send_sample(32'd3670, 1'b1);        // press equal to long threshold is a click
      send_sample(32'd4800, 1'b0);        // long hold
      send_sample(32'd4810, 1'b1);        // long release drops the pending click
      send_sample(32'd5300, 1'b1);
      send_sample(32'hFFFF_FFFF, 1'b1);
      send_sample(32'h0000_0000, 1'b0);   // timestamp wraps
      send_sample(32'h0000_0002, 1'b1);
   endtask

   initial begin : stimulus
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.now_ms    <= '0;
      req_bus.pin_level <= 1'b0;
      csr_bus.valid     <= 1'b0;
      csr_bus.index     <= '0;
      csr_bus.wdata     <= '0;
      stamp   = '0;
      dead_ms = DEAD_WINDOW_RESET;
      long_ms = LONG_THRESH_RESET;
      deb_ms  = DEBOUNCE_RESET;
      act_lvl = ACTIVE_LVL_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      set_idling(35, 74);
      directed_samples();

      configure(32'd0, 32'hFFFF_FFFF, 32'd0, 1'b1);
      hold_ticket <= hold_ticket + 1;
      run_gestures(60);
      configure(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b0);
      run_gestures(50);

      set_idling(74, 35);
      configure($urandom_range(600, 50), $urandom_range(2500, 300), $urandom_range(120),
                1'($urandom_range(1)));
      run_gestures(40);
      wait_idle();
      run_gestures(40);
      configure(32'd5000, 32'd1000, 32'd0, 1'($urandom_range(1)));
      click_flood(FLOOD_CLICKS);

      set_idling(0, 0);
      configure($urandom, $urandom, $urandom, 1'($urandom_range(1)));
      run_gestures(25);
      configure(DEAD_WINDOW_RESET, LONG_THRESH_RESET, DEBOUNCE_RESET, ACTIVE_LVL_RESET);
      stamp = 32'hFFFF_FFFF - $urandom_range(3000);
      run_gestures(35);

      wait_idle();
      if (error_count == 0) begin
         $display("button_multi_click_detector_core verification clean");
      end else begin
         $display("button_multi_click_detector_core verification failed");
      end
      $finish;
   end

endmodule
